>>> design/rhp_pkg.sv
// Shared types and constants for the RTP header parser.
package rhp_pkg;

    localparam int POS_W = 19;

    localparam logic [POS_W-1:0] FIXED_HEADER_BYTES = 19'd12;
    localparam logic [1:0]       RTP_VERSION        = 2'd2;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_MALFORMED = 1'b1;

    // One packet byte as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } rhp_item_t;

    // One parse result.
    typedef struct packed {
        logic             status;
        logic             padding_flag;
        logic             extension_flag;
        logic [3:0]       source_count;
        logic             marker_flag;
        logic [6:0]       payload_type;
        logic [15:0]      seq_number;
        logic [31:0]      time_stamp;
        logic [31:0]      sync_source;
        logic [15:0]      ext_profile;
        logic [15:0]      extension_words;
        logic [POS_W-1:0] header_length;
    } rhp_result_t;

endpackage

>>> design/rhp_if.sv
// Channel interfaces: packet bytes in, parsed headers out.
interface rhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rhp_header_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        padding_flag;
    logic        extension_flag;
    logic [3:0]  source_count;
    logic        marker_flag;
    logic [6:0]  payload_type;
    logic [15:0] seq_number;
    logic [31:0] time_stamp;
    logic [31:0] sync_source;
    logic [15:0] ext_profile;
    logic [15:0] extension_words;
    logic [18:0] header_length;

    modport source (
        output valid, output status, output padding_flag, output extension_flag,
        output source_count, output marker_flag, output payload_type,
        output seq_number, output time_stamp, output sync_source,
        output ext_profile, output extension_words, output header_length,
        input ready
    );
    modport sink (
        input valid, input status, input padding_flag, input extension_flag,
        input source_count, input marker_flag, input payload_type,
        input seq_number, input time_stamp, input sync_source,
        input ext_profile, input extension_words, input header_length,
        output ready
    );
endinterface

>>> design/rhp_input_stage.sv
// Input register that holds one packet byte until the parse core takes it.
module rhp_input_stage
    import rhp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rhp_item_t in_item,
    output logic      item_valid,
    output rhp_item_t item,
    input  logic      item_take
);

    logic      valid_reg;
    rhp_item_t item_reg;

    // Space opens when the held byte is empty or is taken this cycle.
    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Byte payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> design/rhp_parse_core.sv
// Byte-position tracking, header field capture and result decision.
module rhp_parse_core
    import rhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  rhp_item_t   item,
    output logic        result_fire,
    output rhp_result_t result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] req_reg, req_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       second_reg, second_next;
    logic [15:0]      seq_reg, seq_next;
    logic [31:0]      ts_reg, ts_next;
    logic [31:0]      src_reg, src_next;
    logic [15:0]      prof_reg, prof_next;
    logic [15:0]      len_reg, len_next;
    logic             reported_reg, reported_next;

    logic [6:0]       ext_base;
    logic [6:0]       ext_base_new;
    logic [POS_W-1:0] ext_base_w;
    logic [POS_W:0]   pos_plus1;
    logic             bad;
    logic             done;
    logic [7:0]       b;

    assign b          = item.data_byte;
    assign ext_base   = 7'd12 + {1'b0, first_reg[3:0], 2'b00};
    assign ext_base_w = {{(POS_W-7){1'b0}}, ext_base};
    assign pos_plus1  = {1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1};

    // Next state and result for the byte being taken.
    always_comb
    begin
        pos_next      = pos_reg;
        req_next      = req_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        seq_next      = seq_reg;
        ts_next       = ts_reg;
        src_next      = src_reg;
        prof_next     = prof_reg;
        len_next      = len_reg;
        reported_next = reported_reg;
        ext_base_new  = 7'd12 + {1'b0, b[3:0], 2'b00};
        bad           = 1'b0;
        done          = 1'b0;
        result_fire   = 1'b0;
        result        = '0;

        if (take && !reported_reg)
        begin
            // Field capture by byte position.
            priority if (pos_reg == '0)
            begin
                first_next = b;
                if (b[7:6] != RTP_VERSION)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    req_next = {{(POS_W-7){1'b0}}, ext_base_new}
                             + (b[4] ? 19'd4 : 19'd0);
                end
            end
            else if (pos_reg == 19'd1)
            begin
                second_next = b;
            end
            else if (pos_reg < 19'd4)
            begin
                seq_next = {seq_reg[7:0], b};
            end
            else if (pos_reg < 19'd8)
            begin
                ts_next = {ts_reg[23:0], b};
            end
            else if (pos_reg < FIXED_HEADER_BYTES)
            begin
                src_next = {src_reg[23:0], b};
            end
            else if (first_reg[4] && pos_reg >= ext_base_w)
            begin
                if (pos_reg < ext_base_w + 19'd2)
                begin
                    prof_next = {prof_reg[7:0], b};
                end
                else if (pos_reg < ext_base_w + 19'd4)
                begin
                    len_next = {len_reg[7:0], b};
                    if (pos_reg == ext_base_w + 19'd3)
                    begin
                        req_next = ext_base_w + 19'd4 + {1'b0, len_next, 2'b00};
                    end
                end
            end
            else
            begin
                // CSRC words and extension words carry nothing to capture.
            end

            done = !bad && (pos_plus1 == {1'b0, req_next});

            // Outcome of this byte.
            priority if (bad || done)
            begin
                result_fire   = 1'b1;
                reported_next = 1'b1;
            end
            else if (item.last_byte)
            begin
                result_fire = 1'b1;
            end
            else
            begin
                pos_next = pos_plus1[POS_W-1:0];
            end

            // Result fields, taken before the packet end clears them; a malformed or short
            // packet reports the malformed status with all other fields zero.
            if (done)
            begin
                result.status          = STATUS_OK;
                result.padding_flag    = first_next[5];
                result.extension_flag  = first_next[4];
                result.source_count    = first_next[3:0];
                result.marker_flag     = second_next[7];
                result.payload_type    = second_next[6:0];
                result.seq_number      = seq_next;
                result.time_stamp      = ts_next;
                result.sync_source     = src_next;
                result.ext_profile     = prof_next;
                result.extension_words = len_next;
                result.header_length   = req_next;
            end
            else
            begin
                result.status = STATUS_MALFORMED;
            end
        end

        // The final byte returns the packet state to its start.
        if (take && item.last_byte)
        begin
            pos_next      = '0;
            req_next      = FIXED_HEADER_BYTES;
            first_next    = '0;
            second_next   = '0;
            seq_next      = '0;
            ts_next       = '0;
            src_next      = '0;
            prof_next     = '0;
            len_next      = '0;
            reported_next = 1'b0;
        end
    end

    // Packet state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            req_reg      <= FIXED_HEADER_BYTES;
            first_reg    <= '0;
            second_reg   <= '0;
            seq_reg      <= '0;
            ts_reg       <= '0;
            src_reg      <= '0;
            prof_reg     <= '0;
            len_reg      <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            req_reg      <= req_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            seq_reg      <= seq_next;
            ts_reg       <= ts_next;
            src_reg      <= src_next;
            prof_reg     <= prof_next;
            len_reg      <= len_next;
            reported_reg <= reported_next;
        end
    end

endmodule

>>> design/rhp_output_stage.sv
// Result register that holds one parsed header until the sink takes it.
module rhp_output_stage
    import rhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  rhp_result_t load_result,
    output logic        space,
    output logic        out_valid,
    input  logic        out_ready,
    output rhp_result_t out_result
);

    logic        valid_reg;
    rhp_result_t result_reg;

    // Free when empty or when the held result transfers this cycle.
    assign space      = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load && space)
        begin
            result_reg <= load_result;
        end
    end

endmodule

>>> design/rtp_header_parser_unit.sv
// Top level of the RTP fixed-header parser.
//
//   Channel  Role    Transfer                      Payload
//   pkt      sink    one packet byte               data_byte, last_byte
//   hdr      source  one result per packet         status and header fields
//
// One byte is taken per cycle while hdr does not stall; a byte passes from the input
// register to the parse core, and its result is registered in the output register.
// The parse core updates its field registers as each byte is taken, which sets
// the sustained rate at one byte per clock while hdr does not stall.
// Reset clears the byte position and all captured fields, ready for a new packet.
// A stall on hdr holds the byte in the input register; pkt stays ready while
// either register has room or drains in the same cycle.
module rtp_header_parser_unit
    import rhp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rhp_byte_if.sink     pkt,
    rhp_header_if.source hdr
);

    rhp_item_t   in_item;
    rhp_item_t   item;
    logic        item_valid;
    logic        item_take;
    logic        out_space;
    logic        result_fire;
    rhp_result_t result;
    rhp_result_t out_result;

    assign in_item.data_byte = pkt.data_byte;
    assign in_item.last_byte = pkt.last_byte;
    assign item_take         = item_valid && out_space;

    rhp_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pkt.valid),
        .in_ready   (pkt.ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    rhp_parse_core u_parse_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (item_take),
        .item        (item),
        .result_fire (result_fire),
        .result      (result)
    );

    rhp_output_stage u_output_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (result_fire),
        .load_result (result),
        .space       (out_space),
        .out_valid   (hdr.valid),
        .out_ready   (hdr.ready),
        .out_result  (out_result)
    );

    // Result fields onto the output channel.
    assign hdr.status          = out_result.status;
    assign hdr.padding_flag    = out_result.padding_flag;
    assign hdr.extension_flag  = out_result.extension_flag;
    assign hdr.source_count    = out_result.source_count;
    assign hdr.marker_flag     = out_result.marker_flag;
    assign hdr.payload_type    = out_result.payload_type;
    assign hdr.seq_number      = out_result.seq_number;
    assign hdr.time_stamp      = out_result.time_stamp;
    assign hdr.sync_source     = out_result.sync_source;
    assign hdr.ext_profile     = out_result.ext_profile;
    assign hdr.extension_words = out_result.extension_words;
    assign hdr.header_length   = out_result.header_length;

endmodule
